// ===== hw/rtl/p2rf_pkg.sv =====
// Shared types and codes for the power-of-two ring FIFO.
package p2rf_pkg;

  typedef enum logic [1:0] {
    MODE_WRITE   = 2'd0,
    MODE_READ    = 2'd1,
    MODE_DISCARD = 2'd2,
    MODE_RESET   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_BURST
  } state_t;

  localparam int unsigned COUNT_W = 7;
  localparam int unsigned LOG_W   = 3;
  localparam logic [LOG_W-1:0] LOG_RESET = 3'd6;

  // Controller to datapath
  typedef struct packed {
    logic load;   // capture a new request
    logic exec;   // carry out the captured request
    logic step;   // emit one item of a read burst
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic burst_go;    // read request with at least one item to give
    logic burst_last;  // current burst item is the final one
  } sts_t;

endpackage

// ===== hw/rtl/power_of_two_ring_fifo.sv =====
// Ring FIFO over a power-of-two store with wrap-bit pointers.
// A request is captured in the request registers, carried out in the execute
// state and its result registered at the outputs; a read with items to give
// runs as a burst from the registered store read port, its items on consecutive
// cycles. A new request is taken only while idle. Reset clears both pointers
// and sets the length to 2**LOG_RESET, capped at the store size; the receiver
// cannot stall, so each result is shown for one cycle only.
module power_of_two_ring_fifo #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned ITEM_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   mode,
  input  logic [ITEM_WIDTH-1:0]        item_data,
  input  logic [p2rf_pkg::COUNT_W-1:0] count,
  input  logic                         cfg_we,
  input  logic [p2rf_pkg::LOG_W-1:0]   cfg_wdata,
  output logic                         result_valid,
  output logic [ITEM_WIDTH-1:0]        out_data,
  output logic [1:0]                   status,
  output logic [p2rf_pkg::COUNT_W-1:0] done_count,
  output logic [p2rf_pkg::COUNT_W-1:0] fill_level,
  output logic [p2rf_pkg::COUNT_W-1:0] free_space,
  output logic                         last
);
  import p2rf_pkg::*;

  // largest usable length log2: floor(log2(DEPTH))
  localparam int unsigned MAXLOG = $clog2(DEPTH + 1) - 1;

  cmd_t cmd;
  sts_t sts;

  p2rf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  p2rf_dpath #(
    .MAXLOG     (MAXLOG),
    .ITEM_WIDTH (ITEM_WIDTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .mode         (mode),
    .item_data    (item_data),
    .count        (count),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .result_valid (result_valid),
    .out_data     (out_data),
    .status       (status),
    .done_count   (done_count),
    .fill_level   (fill_level),
    .free_space   (free_space),
    .last         (last)
  );

endmodule

// ===== hw/rtl/p2rf_ctrl.sv =====
// Request sequencer for the ring FIFO.
module p2rf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  p2rf_pkg::sts_t sts,
  output p2rf_pkg::cmd_t cmd
);
  import p2rf_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = sts.burst_go ? ST_BURST : ST_IDLE;
      end
      ST_BURST: begin
        if (sts.burst_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy     = 1'b1;
    cmd.load = 1'b0;
    cmd.exec = 1'b0;
    cmd.step = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_EXEC:  cmd.exec = 1'b1;
      ST_BURST: cmd.step = 1'b1;
      default:  busy = 1'b1;
    endcase
  end

endmodule

// ===== hw/rtl/p2rf_dpath.sv =====
// Pointers, item store and result registers of the ring FIFO.
module p2rf_dpath #(
  parameter int unsigned MAXLOG     = 6,
  parameter int unsigned ITEM_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  p2rf_pkg::cmd_t                   cmd,
  output p2rf_pkg::sts_t                   sts,
  input  logic [1:0]                       mode,
  input  logic [ITEM_WIDTH-1:0]            item_data,
  input  logic [p2rf_pkg::COUNT_W-1:0]     count,
  input  logic                             cfg_we,
  input  logic [p2rf_pkg::LOG_W-1:0]       cfg_wdata,
  output logic                             result_valid,
  output logic [ITEM_WIDTH-1:0]            out_data,
  output logic [1:0]                       status,
  output logic [p2rf_pkg::COUNT_W-1:0]     done_count,
  output logic [p2rf_pkg::COUNT_W-1:0]     fill_level,
  output logic [p2rf_pkg::COUNT_W-1:0]     free_space,
  output logic                             last
);
  import p2rf_pkg::*;

  localparam int unsigned PW    = MAXLOG + 1;
  localparam int unsigned KW    = $clog2(MAXLOG + 1);
  localparam int unsigned SLOTS = 1 << MAXLOG;

  logic [ITEM_WIDTH-1:0] mem [SLOTS];
  logic [ITEM_WIDTH-1:0] rdata;

  logic [PW-1:0]         rptr, rptr_next;
  logic [PW-1:0]         wptr, wptr_next;
  logic [KW-1:0]         klog;
  mode_t                 req_mode;
  logic [ITEM_WIDTH-1:0] req_data;
  logic [COUNT_W-1:0]    req_count;
  logic [COUNT_W-1:0]    remain;
  logic [COUNT_W-1:0]    burst_n;

  logic [PW-1:0]         ptr_mask;
  logic [PW-1:0]         len;
  logic [MAXLOG-1:0]     idx_mask;
  logic [PW-1:0]         fill;
  logic [PW-1:0]         fill_after;
  logic [COUNT_W-1:0]    fill_ext;
  logic [COUNT_W-1:0]    n;
  logic                  mem_we;

  logic                  emit;
  logic [ITEM_WIDTH-1:0] emit_data;
  status_t               emit_status;
  logic [COUNT_W-1:0]    emit_done;
  logic                  emit_last;

  assign ptr_mask = {PW{1'b1}} >> (KW'(MAXLOG) - klog);
  assign len      = (ptr_mask >> 1) + PW'(1);
  assign idx_mask = ptr_mask[PW-1:1];
  assign fill     = (wptr - rptr) & ptr_mask;
  assign fill_ext = COUNT_W'(fill);
  assign n        = (req_count < fill_ext) ? req_count : fill_ext;

  assign sts.burst_go   = (req_mode == MODE_READ) && (n != '0);
  assign sts.burst_last = (remain == COUNT_W'(1));

  always_comb begin
    rptr_next   = rptr;
    wptr_next   = wptr;
    mem_we      = 1'b0;
    emit        = 1'b0;
    emit_data   = '0;
    emit_status = STATUS_OK;
    emit_done   = '0;
    emit_last   = 1'b1;
    if (cmd.exec) begin
      case (req_mode)
        MODE_WRITE: begin
          emit = 1'b1;
          if (fill == len) begin
            emit_status = STATUS_FULL;
          end else begin
            mem_we    = 1'b1;
            wptr_next = (wptr + PW'(1)) & ptr_mask;
            emit_done = COUNT_W'(1);
          end
        end
        MODE_READ: begin
          // a read with items to give runs as a burst instead
          if (fill == '0) begin
            emit        = 1'b1;
            emit_status = STATUS_EMPTY;
          end else if (n == '0) begin
            emit = 1'b1;
          end
        end
        MODE_DISCARD: begin
          emit      = 1'b1;
          rptr_next = (rptr + n[PW-1:0]) & ptr_mask;
          emit_done = n;
        end
        default: begin
          emit      = 1'b1;
          rptr_next = '0;
          wptr_next = '0;
        end
      endcase
    end else if (cmd.step) begin
      emit      = 1'b1;
      emit_data = rdata;
      rptr_next = (rptr + PW'(1)) & ptr_mask;
      emit_done = burst_n;
      emit_last = sts.burst_last;
    end
  end

  assign fill_after = (wptr_next - rptr_next) & ptr_mask;

  // Store and registered read port; read address tracks the next read pointer
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wptr[MAXLOG-1:0] & idx_mask] <= req_data;
    end
    rdata <= mem[rptr_next[MAXLOG-1:0] & idx_mask];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rptr         <= '0;
      wptr         <= '0;
      klog         <= (LOG_RESET > LOG_W'(MAXLOG)) ? KW'(MAXLOG) : KW'(LOG_RESET);
      result_valid <= 1'b0;
    end else if (cfg_we) begin
      // saturate to the store size and restart the queue
      rptr         <= '0;
      wptr         <= '0;
      klog         <= (cfg_wdata > LOG_W'(MAXLOG)) ? KW'(MAXLOG) : KW'(cfg_wdata);
      result_valid <= 1'b0;
    end else begin
      rptr         <= rptr_next;
      wptr         <= wptr_next;
      result_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_mode  <= mode_t'(mode);
      req_data  <= item_data;
      req_count <= count;
    end
    if (cmd.exec) begin
      remain  <= n;
      burst_n <= n;
    end else if (cmd.step) begin
      remain <= remain - COUNT_W'(1);
    end
    if (emit) begin
      out_data   <= emit_data;
      status     <= emit_status;
      done_count <= emit_done;
      fill_level <= COUNT_W'(fill_after);
      free_space <= COUNT_W'(len - fill_after);
      last       <= emit_last;
    end
  end

endmodule

// ===== bench/power_of_two_ring_fifo_tb.sv =====
// Self-checking testbench for the power-of-two ring FIFO: directed and random requests.
`timescale 1ns / 1ps

module power_of_two_ring_fifo_tb;
  import p2rf_pkg::*;

  localparam int unsigned STORE_DEPTH    = 64;
  localparam int unsigned STORE_LOG2     = 6;
  localparam int unsigned WATCHDOG_LIMIT = 400;
  localparam int unsigned PRINT_LIMIT    = 100;

  typedef struct {
    logic [31:0]        data;
    status_t            st;
    logic [COUNT_W-1:0] done;
    logic [COUNT_W-1:0] level;
    logic [COUNT_W-1:0] room;
    logic               lst;
  } fifo_result_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         mode;
  logic [31:0]        item_data;
  logic [COUNT_W-1:0] count;
  logic               cfg_we;
  logic [LOG_W-1:0]   cfg_wdata;
  logic               result_valid;
  logic [31:0]        out_data;
  logic [1:0]         status;
  logic [COUNT_W-1:0] done_count;
  logic [COUNT_W-1:0] fill_level;
  logic [COUNT_W-1:0] free_space;
  logic               last;

  // Mirror of the FIFO contents and pointers
  logic [31:0]      shadow_items [STORE_DEPTH];
  int unsigned      rd_ptr;
  int unsigned      wr_ptr;
  logic [LOG_W-1:0] len_log2;

  fifo_result_t fifo_results_due [$];
  fifo_result_t head_due;

  int error_count;
  int quiet_cycles;
  int burst_left;
  bit pace_on;

  power_of_two_ring_fifo #(
    .DEPTH      (STORE_DEPTH),
    .ITEM_WIDTH (32)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .item_data    (item_data),
    .count        (count),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .result_valid (result_valid),
    .out_data     (out_data),
    .status       (status),
    .done_count   (done_count),
    .fill_level   (fill_level),
    .free_space   (free_space),
    .last         (last)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int unsigned queue_length();
    int unsigned k;
    k = (len_log2 > STORE_LOG2) ? STORE_LOG2 : len_log2;
    return 1 << k;
  endfunction

  function automatic int unsigned fill_count();
    return (wr_ptr - rd_ptr) & (2 * queue_length() - 1);
  endfunction

  function automatic void push_due(input logic [31:0] d, input status_t st,
                                   input int unsigned done, input bit lst);
    fifo_result_t r;
    r.data  = d;
    r.st    = st;
    r.done  = done[COUNT_W-1:0];
    r.level = COUNT_W'(fill_count());
    r.room  = COUNT_W'(queue_length() - fill_count());
    r.lst   = lst;
    fifo_results_due.push_back(r);
  endfunction

  // Advance the mirror by one accepted request and queue its results
  function automatic void apply_fifo_request(input mode_t m, input logic [31:0] d,
                                             input logic [COUNT_W-1:0] n);
    int unsigned len;
    int unsigned msk;
    int unsigned lvl;
    int unsigned take;
    int unsigned i;
    logic [31:0] v;
    len  = queue_length();
    msk  = 2 * len - 1;
    lvl  = fill_count();
    take = (n < lvl) ? n : lvl;
    case (m)
      MODE_WRITE: begin
        if (lvl >= len) begin
          push_due('0, STATUS_FULL, 0, 1'b1);
        end else begin
          shadow_items[wr_ptr & (len - 1)] = d;
          wr_ptr = (wr_ptr + 1) & msk;
          push_due('0, STATUS_OK, 1, 1'b1);
        end
      end
      MODE_READ: begin
        if (lvl == 0) begin
          push_due('0, STATUS_EMPTY, 0, 1'b1);
        end else if (take == 0) begin
          push_due('0, STATUS_OK, 0, 1'b1);
        end else begin
          for (i = 0; i < take; i++) begin
            v = shadow_items[rd_ptr & (len - 1)];
            rd_ptr = (rd_ptr + 1) & msk;
            push_due(v, STATUS_OK, take, i + 1 == take);
          end
        end
      end
      MODE_DISCARD: begin
        rd_ptr = (rd_ptr + take) & msk;
        push_due('0, STATUS_OK, take, 1'b1);
      end
      default: begin
        rd_ptr = 0;
        wr_ptr = 0;
        push_due('0, STATUS_OK, 0, 1'b1);
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    // Keep the log short on a badly broken build; every mismatch still counts
    if (error_count <= PRINT_LIMIT)
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  // Hold the request until accepted, then pace the next one when pacing is on
  task automatic send_request(input mode_t m, input logic [31:0] d,
                              input logic [COUNT_W-1:0] n);
    start     <= 1'b1;
    mode      <= m;
    item_data <= d;
    count     <= n;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_fifo_request(m, d, n);
    if (pace_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 8);
        start <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_until_idle();
    start <= 1'b0;
    while (fifo_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_queue_length(input logic [LOG_W-1:0] v);
    wait_until_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    // A length write re-initializes the queue
    len_log2 = v;
    rd_ptr   = 0;
    wr_ptr   = 0;
  endtask

  task automatic test_directed_modes();
    send_request(MODE_READ,    32'h1111_1111, 7'd5);
    send_request(MODE_DISCARD, 32'h2222_2222, 7'd3);
    send_request(MODE_WRITE,   32'h0000_0000, 7'd0);
    send_request(MODE_WRITE,   32'hFFFF_FFFF, 7'd127);
    send_request(MODE_WRITE,   32'hA5A5_A5A5, 7'd64);
    send_request(MODE_READ,    32'h0,         7'd0);
    send_request(MODE_READ,    32'hFFFF_FFFF, 7'd1);
    send_request(MODE_DISCARD, 32'h0,         7'd1);
    send_request(MODE_READ,    32'h0,         7'd64);
    send_request(MODE_WRITE,   32'h5A5A_5A5A, 7'd0);
    send_request(MODE_WRITE,   32'h1234_5678, 7'd0);
    send_request(MODE_RESET,   32'hDEAD_BEEF, 7'd64);
    send_request(MODE_READ,    32'h0,         7'd2);
    send_request(MODE_WRITE,   32'h8000_0001, 7'd0);
    send_request(MODE_DISCARD, 32'h0,         7'd0);
    send_request(MODE_DISCARD, 32'h0,         7'd64);
    send_request(MODE_READ,    32'h0,         7'd64);
  endtask

  task automatic test_full_and_wrap();
    // Single-entry queue: drop on full, drain, drop again
    set_queue_length(3'd0);
    send_request(MODE_WRITE,   32'hCAFE_0001, 7'd0);
    send_request(MODE_WRITE,   32'hCAFE_0002, 7'd0);
    send_request(MODE_READ,    32'h0,         7'd1);
    send_request(MODE_READ,    32'h0,         7'd1);
    send_request(MODE_WRITE,   32'hCAFE_0003, 7'd0);
    send_request(MODE_DISCARD, 32'h0,         7'd64);
    // Two-entry queue: wrap the pointers
    set_queue_length(3'd1);
    send_request(MODE_WRITE,   32'hBEEF_0001, 7'd0);
    send_request(MODE_WRITE,   32'hBEEF_0002, 7'd0);
    send_request(MODE_WRITE,   32'hBEEF_0003, 7'd0);
    send_request(MODE_READ,    32'h0,         7'd1);
    send_request(MODE_WRITE,   32'hBEEF_0004, 7'd0);
    send_request(MODE_READ,    32'h0,         7'd64);
    // Oversized length saturates to the full store
    set_queue_length(3'd7);
    send_request(MODE_WRITE,   32'h7777_7777, 7'd0);
    send_request(MODE_READ,    32'h0,         7'd3);
  endtask

  task automatic run_random_traffic(input logic [LOG_W-1:0] log_sel,
                                    input int unsigned n_items, input bit paced);
    int unsigned len;
    int unsigned pick;
    int unsigned cnt;
    int unsigned k;
    bit filling;
    mode_t m;
    set_queue_length(log_sel);
    pace_on = paced;
    filling = 1'b1;
    for (k = 0; k < n_items; k++) begin
      len  = queue_length();
      pick = $urandom_range(0, 99);
      // Sweep between full and empty so both ends of the ring get exercised
      if (filling) begin
        if (pick < 72)      m = MODE_WRITE;
        else if (pick < 86) m = MODE_READ;
        else if (pick < 97) m = MODE_DISCARD;
        else                m = MODE_RESET;
      end else begin
        if (pick < 20)      m = MODE_WRITE;
        else if (pick < 72) m = MODE_READ;
        else if (pick < 97) m = MODE_DISCARD;
        else                m = MODE_RESET;
      end
      pick = $urandom_range(0, 9);
      if (pick == 0)      cnt = 64;
      else if (pick == 1) cnt = $urandom_range(0, 64);
      else                cnt = $urandom_range(0, (len < 8) ? len : 8);
      send_request(m, $urandom, cnt[COUNT_W-1:0]);
      if (fill_count() >= len)    filling = 1'b0;
      else if (fill_count() == 0) filling = 1'b1;
    end
  endtask

  task automatic test_random_traffic();
    run_random_traffic(3'd7, 60, 1'b1);
    run_random_traffic(3'd0, 16, 1'b1);
    run_random_traffic(3'd1, 24, 1'b0);
    run_random_traffic(3'd2, 30, 1'b1);
    run_random_traffic(3'd3, 34, 1'b1);
    run_random_traffic(3'd4, 36, 1'b0);
    run_random_traffic(3'd5, 40, 1'b1);
    run_random_traffic(3'd6, 30, 1'b1);
  endtask

  // Compare each result with the oldest one due
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (fifo_results_due.size() == 0) begin
        report_mismatch("unexpected result, out_data", out_data, '0);
      end else begin
        head_due = fifo_results_due.pop_front();
        if (out_data !== head_due.data)
          report_mismatch("out_data", out_data, head_due.data);
        if (status !== head_due.st)
          report_mismatch("status", 32'(status), 32'(head_due.st));
        if (done_count !== head_due.done)
          report_mismatch("done_count", 32'(done_count), 32'(head_due.done));
        if (fill_level !== head_due.level)
          report_mismatch("fill_level", 32'(fill_level), 32'(head_due.level));
        if (free_space !== head_due.room)
          report_mismatch("free_space", 32'(free_space), 32'(head_due.room));
        if (last !== head_due.lst)
          report_mismatch("last", 32'(last), 32'(head_due.lst));
      end
    end
  end

  // Stop a hung run: count cycles with neither a request nor a result moving
  always @(posedge clk) begin
    if (rst || result_valid || (start && !busy))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               fifo_results_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst          <= 1'b1;
    start        <= 1'b0;
    mode         <= MODE_WRITE;
    item_data    <= '0;
    count        <= '0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    error_count  = 0;
    quiet_cycles = 0;
    burst_left   = 0;
    pace_on      = 1'b1;
    len_log2     = LOG_RESET;
    rd_ptr       = 0;
    wr_ptr       = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_modes();
    test_full_and_wrap();
    test_random_traffic();

    wait_until_idle();
    repeat (8) @(posedge clk);
    if (fifo_results_due.size() != 0)
      report_mismatch("results never delivered", fifo_results_due.size(), 0);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
